FILE: src/mmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmd_pkg
// Shared constants and codes for the mipmap box downsampler.
// ---------------------------------------------------------------------------
package mmd_pkg;
    localparam int MAX_LOG2_SIZE = 11;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 4;
    localparam int CH_W          = 8;
    localparam int NUM_CH        = 4;
    localparam int PX_W          = CH_W * NUM_CH;
    localparam int SUM_W         = (CH_W + 1) * NUM_CH;
    localparam int LEVEL_W       = 4;
    localparam int POS_W         = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG2_WIDTH   = 8'd0,
        REG_LOG2_HEIGHT  = 8'd1,
        REG_CHANNEL_MODE = 8'd2,
        REG_MAKE_MIPS    = 8'd3
    } t_reg_idx;

    localparam logic [3:0] RST_LOG2_WIDTH  = 4'd8;
    localparam logic [3:0] RST_LOG2_HEIGHT = 4'd8;
endpackage
`default_nettype wire

FILE: src/mmd_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmd interfaces
// Valid/ready channels for pixels, results and register writes.
// ---------------------------------------------------------------------------
interface mmd_px_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface mmd_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] level;
    logic [9:0] col;
    logic [9:0] row;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       last;
    modport source (output valid, level, col, row, out_red, out_green, out_blue,
                    out_alpha, last, input ready);
    modport sink   (input valid, level, col, row, out_red, out_green, out_blue,
                    out_alpha, last, output ready);
endinterface

interface mmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [3:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/mmd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmd_cell
// One mip level: raster counters, held left pixel and horizontal pair sum.
// ---------------------------------------------------------------------------
module mmd_cell #(
    parameter int MAX_LOG2 = mmd_pkg::MAX_LOG2_SIZE,
    parameter int LEV      = 0
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_clr,
    input  wire logic                      i_en,
    input  wire logic [3:0]                i_lw,
    input  wire logic [3:0]                i_lh,
    input  wire logic [mmd_pkg::PX_W-1:0]  i_px,
    output logic [MAX_LOG2-1:0]            o_col,
    output logic [MAX_LOG2-1:0]            o_row,
    output logic [MAX_LOG2-1:0]            o_cc,
    output logic                           o_w1,
    output logic                           o_h1,
    output logic                           o_codd,
    output logic                           o_rodd,
    output logic                           o_emits,
    output logic [mmd_pkg::SUM_W-1:0]      o_pair
);
    localparam int CW = MAX_LOG2;
    localparam logic [4:0] LEV_C = 5'(LEV);

    logic [CW-1:0] r_c, r_r, n_c, n_r;
    logic [mmd_pkg::PX_W-1:0] r_held;
    logic [CW:0] w, h;
    logic [CW-1:0] c, r;

    always_comb begin
        w = ({1'b0, i_lw} <= LEV_C) ? (CW+1)'(1) : (CW+1)'(1) << (i_lw - LEV_C[3:0]);
        h = ({1'b0, i_lh} <= LEV_C) ? (CW+1)'(1) : (CW+1)'(1) << (i_lh - LEV_C[3:0]);
        c = ({1'b0, r_c} < w) ? r_c : '0;
        r = ({1'b0, r_r} < h) ? r_r : '0;
        if ({1'b0, c} + (CW+1)'(1) >= w) begin
            n_c = '0;
            n_r = ({1'b0, r} + (CW+1)'(1) >= h) ? '0 : r + CW'(1);
        end else begin
            n_c = c + CW'(1);
            n_r = r;
        end
    end

    assign o_col   = r_c;
    assign o_row   = r_r;
    assign o_w1    = (w == (CW+1)'(1));
    assign o_h1    = (h == (CW+1)'(1));
    assign o_codd  = c[0];
    assign o_rodd  = r[0];
    assign o_cc    = o_w1 ? '0 : (c >> 1);
    assign o_emits = (o_w1 | o_codd) & (o_h1 | o_rodd);

    always_comb begin
        for (int ch = 0; ch < mmd_pkg::NUM_CH; ch++) begin
            if (o_w1)
                o_pair[ch*9 +: 9] = {i_px[ch*8 +: 8], 1'b0};
            else
                o_pair[ch*9 +: 9] = {1'b0, r_held[ch*8 +: 8]} + {1'b0, i_px[ch*8 +: 8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_c <= '0;
            r_r <= '0;
        end else if (i_en) begin
            r_c <= n_c;
            r_r <= n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !o_w1 && !o_codd)
            r_held <= i_px;
    end
endmodule
`default_nettype wire

FILE: src/mipmap_box_downsampler.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mipmap_box_downsampler
// Streams base pixels in raster order and emits all smaller mip levels.
// ---------------------------------------------------------------------------
// Channels: i_pix takes one base pixel per item; o_res gives mip pixels
// (level, col, row, averaged channels, last on the final result of the item);
// i_cfg writes registers (0 log2 width, 1 log2 height, 2 channel mode,
// 3 make mips). A write to one of these registers clears the level counters and starts a new texture.
// Writes are taken only while idle, ahead of a pixel offered in the same cycle.
// A row of level cells holds per-level counters and held pixels; a token
// walks the row one level at a time. Each level passes the horizontal step;
// a level that emits adds the line buffer read when a 2x2 block closes,
// then the output step. With mips off or a one by one base the block stays
// idle; else an item keeps it busy until a level makes no result or the
// last result is taken, not counting stalls. The next item can be taken
// once the block is back in idle. One item is in work at a time.
// Line buffer: one 2^MAX_LOG2_SIZE x 36 memory shared by all levels.
// Reset: synchronous, active low; registers go to 8, 8, RGB, mips on.
// A stalled o_res holds the result and the block waits.
// ---------------------------------------------------------------------------
module mipmap_box_downsampler #(
    parameter int MAX_LOG2_SIZE = mmd_pkg::MAX_LOG2_SIZE
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mmd_px_if.sink    i_pix,
    mmd_res_if.source o_res,
    mmd_cfg_if.sink   i_cfg
);
    localparam int CW = MAX_LOG2_SIZE;
    localparam int LW = $clog2(MAX_LOG2_SIZE + 1);
    localparam int NC = MAX_LOG2_SIZE + 1;
    localparam logic [3:0] MAXC = 4'(MAX_LOG2_SIZE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HOR  = 4'b0010,
        S_VER  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    logic [3:0] r_lw_raw, r_lh_raw;
    logic       r_mode, r_mips;
    logic [3:0] lw, lh, nl;
    logic [LW-1:0] r_lev;
    logic [LW-1:0] lev1;
    logic [CW-1:0] r_off;
    logic [mmd_pkg::PX_W-1:0]  r_px;
    logic [mmd_pkg::SUM_W-1:0] r_pair;
    logic [mmd_pkg::SUM_W-1:0] mem [0:(1<<CW)-1];
    logic [mmd_pkg::SUM_W-1:0] r_rd;
    logic [CW-1:0] idx;
    logic cfg_wr, clr, pix_acc;

    logic [CW-1:0] c_col [0:NC-1];
    logic [CW-1:0] c_row [0:NC-1];
    logic [CW-1:0] c_cc  [0:NC-1];
    logic [NC-1:0] c_w1, c_h1, c_codd, c_rodd, c_emits, c_en;
    logic [mmd_pkg::SUM_W-1:0] c_pair [0:NC-1];

    logic [mmd_pkg::SUM_W-1:0] pair_cur;
    logic [mmd_pkg::PX_W-1:0]  avg_h, avg_v;
    logic [CW-1:0] dim_next;
    logic at_top;
    logic is_last;

    assign lw = (r_lw_raw > MAXC) ? MAXC : r_lw_raw;
    assign lh = (r_lh_raw > MAXC) ? MAXC : r_lh_raw;
    assign nl = (lw > lh) ? lw : lh;

    assign cfg_wr  = i_cfg.valid & i_cfg.ready;
    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_pix.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign pix_acc = i_pix.valid & i_pix.ready;
    assign clr = cfg_wr && (i_cfg.index == mmd_pkg::REG_LOG2_WIDTH
                         || i_cfg.index == mmd_pkg::REG_LOG2_HEIGHT
                         || i_cfg.index == mmd_pkg::REG_CHANNEL_MODE
                         || i_cfg.index == mmd_pkg::REG_MAKE_MIPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw_raw <= mmd_pkg::RST_LOG2_WIDTH;
            r_lh_raw <= mmd_pkg::RST_LOG2_HEIGHT;
            r_mode   <= 1'b0;
            r_mips   <= 1'b1;
        end else if (cfg_wr) begin
            case (i_cfg.index)
                mmd_pkg::REG_LOG2_WIDTH:   r_lw_raw <= i_cfg.data;
                mmd_pkg::REG_LOG2_HEIGHT:  r_lh_raw <= i_cfg.data;
                mmd_pkg::REG_CHANNEL_MODE: r_mode   <= i_cfg.data[0];
                mmd_pkg::REG_MAKE_MIPS:    r_mips   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++) begin : g_cell
            assign c_en[gi] = (r_state == S_HOR) && (r_lev == LW'(gi));
            mmd_cell #(.MAX_LOG2(MAX_LOG2_SIZE), .LEV(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_clr   (clr),
                .i_en    (c_en[gi]),
                .i_lw    (lw),
                .i_lh    (lh),
                .i_px    (r_px),
                .o_col   (c_col[gi]),
                .o_row   (c_row[gi]),
                .o_cc    (c_cc[gi]),
                .o_w1    (c_w1[gi]),
                .o_h1    (c_h1[gi]),
                .o_codd  (c_codd[gi]),
                .o_rodd  (c_rodd[gi]),
                .o_emits (c_emits[gi]),
                .o_pair  (c_pair[gi])
            );
        end
    endgenerate

    assign lev1     = r_lev + LW'(1);
    assign pair_cur = c_pair[r_lev];
    assign idx      = r_off + c_cc[r_lev];
    // the next level still has to take this pixel unless it is the last level
    assign at_top   = ({{(5-LW){1'b0}}, lev1} == {1'b0, nl});
    assign is_last  = at_top || !c_emits[lev1];
    // size of level lev+1 along the width, for the next line buffer offset
    assign dim_next = ({{(5-LW){1'b0}}, lev1} >= {1'b0, lw}) ? CW'(1)
                    : CW'((CW+1)'(1) << (lw - 4'(lev1)));

    always_comb begin
        for (int ch = 0; ch < mmd_pkg::NUM_CH; ch++) begin
            avg_h[ch*8 +: 8] = pair_cur[ch*9+1 +: 8];
            avg_v[ch*8 +: 8] = 8'(({1'b0, r_rd[ch*9 +: 9]} + {1'b0, r_pair[ch*9 +: 9]}) >> 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_HOR && (c_w1[r_lev] || c_codd[r_lev]) && !c_h1[r_lev]
            && !c_rodd[r_lev])
            mem[idx] <= pair_cur;
        r_rd <= mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_res.valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (pix_acc && r_mips && nl != 4'd0) r_state <= S_HOR;
                S_HOR: begin
                    if (!c_w1[r_lev] && !c_codd[r_lev]) begin
                        r_state <= S_IDLE;
                    end else if (c_h1[r_lev]) begin
                        r_state <= S_OUT;
                        o_res.valid <= 1'b1;
                    end else if (!c_rodd[r_lev]) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_VER;
                    end
                end
                S_VER: begin
                    r_state <= S_OUT;
                    o_res.valid <= 1'b1;
                end
                S_OUT: if (o_res.ready) begin
                    o_res.valid <= 1'b0;
                    r_state <= at_top ? S_IDLE : S_HOR;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_px  <= {r_mode ? i_pix.alpha : 8'd0, i_pix.blue, i_pix.green, i_pix.red};
            r_lev <= '0;
            r_off <= '0;
        end
        if (r_state == S_HOR) begin
            r_pair <= pair_cur;
            o_res.level <= 4'(lev1);
            o_res.col   <= 10'(c_col[lev1]);
            o_res.row   <= 10'(c_row[lev1]);
            o_res.last  <= is_last;
        end
        if (r_state == S_HOR && c_h1[r_lev]) begin
            r_px <= avg_h;
            {o_res.out_alpha, o_res.out_blue, o_res.out_green, o_res.out_red} <= avg_h;
        end
        if (r_state == S_VER) begin
            r_px <= avg_v;
            {o_res.out_alpha, o_res.out_blue, o_res.out_green, o_res.out_red} <= avg_v;
        end
        if (r_state == S_OUT && o_res.ready && !at_top) begin
            r_lev <= lev1;
            r_off <= r_off + dim_next;
        end
    end
endmodule
`default_nettype wire
